>>> hw/rtl/rclcp_pkg.sv
// shared types, codes, command texts and character helpers for the rc link command parser
// no dependencies

package rclcp_pkg;

   localparam int LINE_MAX_DEFAULT = 40;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int REQ_DATA_W       = 48;
   localparam int RSP_DATA_W       = 32;

   localparam logic [7:0]  INIT_SPEED_RESET = 8'd200;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1500;
   localparam logic [7:0]  SPEED_BASE       = 8'd120;
   localparam logic [7:0]  SPEED_STEP       = 8'd15;
   localparam logic [7:0]  PAIR_NEGATIVE    = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_SPEED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_MS    = 2'd1;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_N     = 8'h4E;

   typedef enum logic [2:0] {
      ACT_DRIVE     = 3'd0,
      ACT_STOP      = 3'd1,
      ACT_SET_MODE  = 3'd2,
      ACT_SET_TIME  = 3'd3,
      ACT_ALARM_ON  = 3'd4,
      ACT_ALARM_OFF = 3'd5,
      ACT_UNKNOWN   = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      DIR_FWD         = 3'd0,
      DIR_BACK        = 3'd1,
      DIR_PIVOT_LEFT  = 3'd2,
      DIR_PIVOT_RIGHT = 3'd3,
      DIR_CURVE_LEFT  = 3'd4,
      DIR_CURVE_RIGHT = 3'd5
   } direction_type;

   // line commands; the first five match the mode codes
   typedef enum logic [2:0] {
      CMD_MODE_EVA   = 3'd0,
      CMD_MODE_PET   = 3'd1,
      CMD_MODE_CLOCK = 3'd2,
      CMD_MODE_SLEEP = 3'd3,
      CMD_MODE_RC    = 3'd4,
      CMD_ALARM_OFF  = 3'd5,
      CMD_TIME       = 3'd6,
      CMD_ALARM      = 3'd7
   } cmd_type;

   localparam int NUM_CMD = 8;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] direction;
      logic [7:0] speed;
      logic [2:0] mode;
      logic [4:0] hour;
      logic [5:0] minute;
   } result_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
      logic eval;
      logic push;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_last;
      logic res_valid;
      logic out_free;
   } dp_status_type;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
             c == 8'h0C || c == 8'h0D;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

   function automatic logic [3:0] cmd_len(input cmd_type k);
      logic [3:0] n;
      case (k)
         CMD_MODE_EVA:   n = 4'd8;
         CMD_MODE_PET:   n = 4'd8;
         CMD_MODE_CLOCK: n = 4'd10;
         CMD_MODE_SLEEP: n = 4'd10;
         CMD_MODE_RC:    n = 4'd7;
         CMD_ALARM_OFF:  n = 4'd9;
         CMD_TIME:       n = 4'd5;
         default:        n = 4'd6;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] cmd_char(input cmd_type k, input logic [3:0] i);
      logic [79:0] txt;
      logic [3:0]  n;
      case (k)
         CMD_MODE_EVA:   txt = 80'("MODE EVA");
         CMD_MODE_PET:   txt = 80'("MODE PET");
         CMD_MODE_CLOCK: txt = 80'("MODE CLOCK");
         CMD_MODE_SLEEP: txt = 80'("MODE SLEEP");
         CMD_MODE_RC:    txt = 80'("MODE RC");
         CMD_ALARM_OFF:  txt = 80'("ALARM OFF");
         CMD_TIME:       txt = 80'("TIME ");
         default:        txt = 80'("ALARM ");
      endcase
      n = cmd_len(k);
      if (i < n) begin
         return txt[8*(n-4'd1-i) +: 8];
      end
      return 8'h00;
   endfunction

   // two-character integer read: blanks, optional sign, digits
   function automatic logic [7:0] pair_value(input logic [7:0] c0, input logic [7:0] c1);
      logic [7:0] v;
      logic       neg;
      logic       after;
      logic       stop;
      logic [7:0] c;
      v     = 8'd0;
      neg   = 1'b0;
      after = 1'b0;
      stop  = 1'b0;
      for (int k = 0; k < 2; k++) begin
         c = (k == 0) ? c0 : c1;
         if (!stop) begin
            if (!after && is_blank(c)) begin
               v = v;
            end else if (!after && (c == CH_PLUS || c == CH_MINUS)) begin
               neg   = (c == CH_MINUS);
               after = 1'b1;
            end else if (is_digit(c)) begin
               v     = v * 8'd10 + {4'd0, c[3:0]};
               after = 1'b1;
            end else begin
               stop = 1'b1;
            end
         end
      end
      if (neg && v != 8'd0) begin
         return PAIR_NEGATIVE;
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/rclcp_ctrl.sv
// sequencing controller: accepts items, steps the datapath via exec, scan, eval and push
// depends on rclcp_pkg

module rclcp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rclcp_pkg::dp_status_type status,
   output rclcp_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_PUSH
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= status.scan_needed ? ST_SCAN : ST_PUSH;
            end
            ST_SCAN: begin
               if (status.scan_last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: state_ff <= ST_EVAL;
            ST_EVAL:  state_ff <= ST_PUSH;
            ST_PUSH: begin
               if (!status.res_valid || status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.scan    = (state_ff == ST_SCAN);
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.push    = (state_ff == ST_PUSH) && status.res_valid && status.out_free;
   end

endmodule

>>> hw/rtl/rclcp_datapath.sv
// datapath: item registers, line store, drive state, line matcher and result registers
// depends on rclcp_pkg

module rclcp_datapath #(
   parameter int LINE_MAX = rclcp_pkg::LINE_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rclcp_pkg::dp_cmd_type               cmd,
   output rclcp_pkg::dp_status_type            status,
   input  logic                                in_func,
   input  logic [7:0]                          in_byte,
   input  logic [31:0]                         in_now,
   input  logic                                in_rc,
   input  logic                                in_moving,
   input  logic                                cfg_we,
   input  logic [rclcp_pkg::CSR_INDEX_W-1:0]   cfg_index,
   input  logic [rclcp_pkg::CSR_DATA_W-1:0]    cfg_data,
   input  logic                                out_ready,
   output logic                                out_valid,
   output rclcp_pkg::result_type               out_result
);

   localparam int AW = $clog2(LINE_MAX);
   localparam int LW = $clog2(LINE_MAX + 1);
   localparam int TAIL_POS = 12;
   localparam int CAP_POS  = 5;
   localparam int CAP_N    = 7;
   localparam int NUM_MATCH = rclcp_pkg::NUM_CMD;

   typedef enum logic [1:0] {
      TAIL_SKIP,
      TAIL_O,
      TAIL_ON,
      TAIL_FAIL
   } tail_type;

   logic        func_ff, rc_ff, moving_ff;
   logic [7:0]  byte_ff;
   logic [31:0] now_ff;

   logic [7:0]    mem [LINE_MAX];
   logic          mem_we;
   logic [LW-1:0] len_ff, len_in;
   logic          seen_ff, seen_in;
   logic [AW-1:0] first_ff, first_in;
   logic [LW-1:0] end_ff, end_in;

   logic [15:0] timeout_ff;
   logic [7:0]  speed_ff, speed_in;
   logic [31:0] last_ff, last_in;

   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] stop_ff, stop_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [7:0]    q_ff;
   logic          qv_ff;
   logic [NUM_MATCH-1:0] match_ff, match_in;
   logic [7:0]    cap_ff [CAP_N];
   tail_type      tail_ff, tail_in;

   rclcp_pkg::result_type res_ff, res_in;
   logic                  res_valid_ff, res_valid_in;
   rclcp_pkg::result_type out_ff;
   logic                  out_valid_ff;

   logic       is_eol, is_drive, line_live;
   logic [7:0] u;
   logic [LW-1:0] trim_n;
   rclcp_pkg::result_type eval_res;
   logic                  eval_valid;
   logic [7:0] t_h, t_m, a_h, a_m;
   logic       a_nospace;

   always_comb begin
      is_eol    = (byte_ff == rclcp_pkg::CH_LF) || (byte_ff == rclcp_pkg::CH_CR);
      is_drive  = rclcp_pkg::is_digit(byte_ff) || byte_ff == "F" || byte_ff == "B" ||
                  byte_ff == "L" || byte_ff == "R" || byte_ff == "G" || byte_ff == "I" ||
                  byte_ff == "H" || byte_ff == "J" || byte_ff == "S";
      line_live = (len_ff != '0) && seen_ff;
      trim_n    = end_ff - LW'(first_ff);
   end

   // item execution
   always_comb begin
      len_in       = len_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      speed_in     = speed_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      stop_in      = stop_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff;
      mem_we       = 1'b0;
      if (cmd.exec) begin
         res_in       = '0;
         res_valid_in = 1'b0;
         if (func_ff) begin
            res_in.action = rclcp_pkg::ACT_STOP;
            res_valid_in  = rc_ff && moving_ff && ((now_ff - last_ff) > {16'd0, timeout_ff});
         end else if (is_eol) begin
            len_in  = '0;
            seen_in = 1'b0;
            addr_in = first_ff;
            stop_in = AW'(end_ff - LW'(1));
            n_in    = trim_n;
         end else if (len_ff == '0 && is_drive) begin
            if (rc_ff) begin
               last_in = now_ff;
               if (byte_ff == "S") begin
                  res_in.action = rclcp_pkg::ACT_STOP;
                  res_valid_in  = 1'b1;
               end else if (rclcp_pkg::is_digit(byte_ff)) begin
                  speed_in = rclcp_pkg::SPEED_BASE +
                             {4'd0, byte_ff[3:0]} * rclcp_pkg::SPEED_STEP;
               end else begin
                  res_in.action = rclcp_pkg::ACT_DRIVE;
                  res_in.speed  = speed_ff;
                  res_valid_in  = 1'b1;
                  case (byte_ff)
                     "F":      res_in.direction = rclcp_pkg::DIR_FWD;
                     "B":      res_in.direction = rclcp_pkg::DIR_BACK;
                     "L", "H": res_in.direction = rclcp_pkg::DIR_PIVOT_LEFT;
                     "R", "J": res_in.direction = rclcp_pkg::DIR_PIVOT_RIGHT;
                     "G":      res_in.direction = rclcp_pkg::DIR_CURVE_LEFT;
                     default:  res_in.direction = rclcp_pkg::DIR_CURVE_RIGHT;
                  endcase
               end
            end
         end else if (len_ff == LW'(LINE_MAX)) begin
            len_in  = '0;
            seen_in = 1'b0;
         end else begin
            mem_we = 1'b1;
            len_in = len_ff + LW'(1);
            if (!rclcp_pkg::is_blank(byte_ff)) begin
               if (!seen_ff) first_in = len_ff[AW-1:0];
               seen_in = 1'b1;
               end_in  = len_ff + LW'(1);
            end
         end
      end else if (cmd.scan) begin
         addr_in = addr_ff + AW'(1);
      end else if (cmd.eval) begin
         res_in       = eval_res;
         res_valid_in = eval_valid;
      end else if (cmd.push) begin
         res_valid_in = 1'b0;
      end
      if (cfg_we && cfg_index == rclcp_pkg::REG_INITIAL_SPEED) begin
         speed_in = cfg_data[7:0];
      end
   end

   // per-character matcher on the trimmed line
   always_comb begin
      u        = rclcp_pkg::to_upper(q_ff);
      match_in = match_ff;
      tail_in  = tail_ff;
      pos_in   = pos_ff;
      if (cmd.exec) begin
         match_in = '1;
         tail_in  = TAIL_SKIP;
         pos_in   = '0;
      end else if (qv_ff) begin
         pos_in = pos_ff + LW'(1);
         for (int k = 0; k < NUM_MATCH; k++) begin
            if (pos_ff < LW'(rclcp_pkg::cmd_len(rclcp_pkg::cmd_type'(k)))) begin
               match_in[k] = match_ff[k] &&
                  (u == rclcp_pkg::cmd_char(rclcp_pkg::cmd_type'(k), pos_ff[3:0]));
            end else if (k < int'(rclcp_pkg::CMD_TIME)) begin
               match_in[k] = 1'b0;
            end
         end
         if (pos_ff >= LW'(TAIL_POS)) begin
            case (tail_ff)
               TAIL_SKIP: begin
                  if (u == rclcp_pkg::CH_O) tail_in = TAIL_O;
                  else if (!rclcp_pkg::is_blank(u)) tail_in = TAIL_FAIL;
               end
               TAIL_O:  tail_in = (u == rclcp_pkg::CH_N) ? TAIL_ON : TAIL_FAIL;
               default: tail_in = TAIL_FAIL;
            endcase
         end
      end
   end

   // line verdict
   always_comb begin
      t_h = rclcp_pkg::pair_value(cap_ff[0], cap_ff[1]);
      t_m = rclcp_pkg::pair_value(cap_ff[3], cap_ff[4]);
      a_h = rclcp_pkg::pair_value(cap_ff[1], cap_ff[2]);
      a_m = rclcp_pkg::pair_value(cap_ff[4], cap_ff[5]);
      a_nospace = 1'b1;
      for (int k = 1; k < 6; k++) begin
         if (cap_ff[k] == rclcp_pkg::CH_SPACE) a_nospace = 1'b0;
      end
      eval_res   = '0;
      eval_valid = 1'b0;
      if (match_ff[rclcp_pkg::CMD_MODE_EVA] &&
          n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_MODE_EVA))) begin
         eval_res.action = rclcp_pkg::ACT_SET_MODE;
         eval_res.mode   = rclcp_pkg::CMD_MODE_EVA;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_MODE_PET] &&
                   n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_MODE_PET))) begin
         eval_res.action = rclcp_pkg::ACT_SET_MODE;
         eval_res.mode   = rclcp_pkg::CMD_MODE_PET;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_MODE_CLOCK] &&
                   n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_MODE_CLOCK))) begin
         eval_res.action = rclcp_pkg::ACT_SET_MODE;
         eval_res.mode   = rclcp_pkg::CMD_MODE_CLOCK;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_MODE_SLEEP] &&
                   n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_MODE_SLEEP))) begin
         eval_res.action = rclcp_pkg::ACT_SET_MODE;
         eval_res.mode   = rclcp_pkg::CMD_MODE_SLEEP;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_MODE_RC] &&
                   n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_MODE_RC))) begin
         eval_res.action = rclcp_pkg::ACT_SET_MODE;
         eval_res.mode   = rclcp_pkg::CMD_MODE_RC;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_TIME] &&
                   n_ff >= LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_TIME))) begin
         eval_res.action = rclcp_pkg::ACT_SET_TIME;
         eval_res.hour   = t_h[4:0];
         eval_res.minute = t_m[5:0];
         eval_valid      = (n_ff == LW'(10)) && (cap_ff[2] == rclcp_pkg::CH_COLON) &&
                           (t_h <= 8'd23) && (t_m <= 8'd59);
      end else if (match_ff[rclcp_pkg::CMD_ALARM_OFF] &&
                   n_ff == LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_ALARM_OFF))) begin
         eval_res.action = rclcp_pkg::ACT_ALARM_OFF;
         eval_valid      = 1'b1;
      end else if (match_ff[rclcp_pkg::CMD_ALARM] &&
                   n_ff >= LW'(rclcp_pkg::cmd_len(rclcp_pkg::CMD_ALARM))) begin
         eval_res.action = rclcp_pkg::ACT_ALARM_ON;
         eval_res.hour   = a_h[4:0];
         eval_res.minute = a_m[5:0];
         eval_valid      = (tail_ff == TAIL_ON) && a_nospace &&
                           (cap_ff[6] == rclcp_pkg::CH_SPACE) &&
                           (cap_ff[3] == rclcp_pkg::CH_COLON) &&
                           (a_h <= 8'd23) && (a_m <= 8'd59);
      end else begin
         eval_res.action = rclcp_pkg::ACT_UNKNOWN;
         eval_valid      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[len_ff[AW-1:0]] <= byte_ff;
      if (cmd.scan) q_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= in_func;
         byte_ff   <= in_byte;
         now_ff    <= in_now;
         rc_ff     <= in_rc;
         moving_ff <= in_moving;
      end
      first_ff <= first_in;
      end_ff   <= end_in;
      addr_ff  <= addr_in;
      stop_ff  <= stop_in;
      n_ff     <= n_in;
      pos_ff   <= pos_in;
      match_ff <= match_in;
      tail_ff  <= tail_in;
      res_ff   <= res_in;
      if (qv_ff) begin
         for (int k = 0; k < CAP_N; k++) begin
            if (pos_ff == LW'(CAP_POS + k)) cap_ff[k] <= u;
         end
      end
      if (cmd.push) out_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         seen_ff       <= 1'b0;
         timeout_ff    <= rclcp_pkg::TIMEOUT_RESET;
         speed_ff      <= rclcp_pkg::INIT_SPEED_RESET;
         last_ff       <= '0;
         qv_ff         <= 1'b0;
         res_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         speed_ff     <= speed_in;
         last_ff      <= last_in;
         qv_ff        <= cmd.scan;
         res_valid_ff <= res_valid_in;
         if (cfg_we && cfg_index == rclcp_pkg::REG_TIMEOUT_MS) begin
            timeout_ff <= cfg_data;
         end
         if (cmd.push) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.scan_needed = !func_ff && is_eol && line_live;
      status.scan_last   = (addr_ff == stop_ff);
      status.res_valid   = res_valid_ff;
      status.out_free    = !out_valid_ff || out_ready;
      out_valid          = out_valid_ff;
      out_result         = out_ff;
   end

endmodule

>>> hw/rtl/rc_link_command_parser.sv
// top level of the rc link command parser: stream ports, register port, controller and datapath
// depends on rclcp_pkg, rclcp_ctrl and rclcp_datapath
//
// A byte or tick item is taken in, executed and its result (if any) staged, after which the
// input side is ready again. A CR or LF closing a line that holds non-blank text starts a read
// of the trimmed text out of the single-port line store, one character per cycle, before the
// result is evaluated and staged. The result register lets a finished result wait for the sink
// while the next item is taken. Register writes are accepted in every cycle.

module rc_link_command_parser #(
   parameter int LINE_MAX = rclcp_pkg::LINE_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // byte_value[7:0], now_ms[39:8], rc_active[40], is_moving[41], zero fill
   input  logic [rclcp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // direction[2:0], speed[10:3], mode[13:11], hour[18:14], minute[24:19], zero fill
   output logic [rclcp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // action[2:0]
   output logic [2:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rclcp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rclcp_pkg::CSR_DATA_W-1:0]    csr_data
);

   rclcp_pkg::dp_cmd_type    cmd;
   rclcp_pkg::dp_status_type status;
   rclcp_pkg::result_type    result;

   assign csr_ready = 1'b1;

   rclcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rclcp_datapath #(
      .LINE_MAX (LINE_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_func    (req_tuser[0]),
      .in_byte    (req_tdata[7:0]),
      .in_now     (req_tdata[39:8]),
      .in_rc      (req_tdata[40]),
      .in_moving  (req_tdata[41]),
      .cfg_we     (csr_valid && csr_ready),
      .cfg_index  (csr_index),
      .cfg_data   (csr_data),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (result)
   );

   assign rsp_tuser = result.action;
   assign rsp_tdata = {7'd0, result.minute, result.hour, result.mode, result.speed,
                       result.direction};

endmodule

>>> hw/rtl/rclcp_checker.sv
// port-level checks for the rc link command parser, bound to the top level
// depends on rclcp_pkg and rc_link_command_parser

module rclcp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rclcp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                       rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an item");

   // only drive results carry direction and speed
   a_drive_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rclcp_pkg::ACT_DRIVE |-> rsp_tdata[10:0] == 11'd0)
      else $error("direction or speed on a non-drive result");

   // parsed time in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rclcp_pkg::ACT_SET_TIME ||
                     rsp_tuser == rclcp_pkg::ACT_ALARM_ON)
      |-> rsp_tdata[18:14] <= 5'd23 && rsp_tdata[24:19] <= 6'd59)
      else $error("time out of range");

endmodule

bind rc_link_command_parser rclcp_checker u_rclcp_checker (.*);

>>> verif/tb_top.sv
// self-checking testbench for rc_link_command_parser: directed rows, then random link traffic
// depends on rclcp_pkg and rc_link_command_parser

module tb_top;

   localparam int LINE_CAP    = 40;
   localparam int DRAIN_WAIT  = 60;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      bit          func;
      string       txt;
      bit          term;
      logic [31:0] now;
      bit          rc;
      bit          mov;
      bit          typed;
      rclcp_pkg::result_type res;
   } row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [rclcp_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic [0:0]                        req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [rclcp_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [2:0]                        rsp_tuser;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [rclcp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rclcp_pkg::CSR_DATA_W-1:0]  csr_data;

   // predictor state
   logic [7:0]  line_buf [0:LINE_CAP-1];
   logic [7:0]  folded [0:LINE_CAP-1];
   int          line_len;
   logic [7:0]  cur_speed;
   logic [15:0] wd_timeout;
   logic [31:0] last_cmd_ms;

   rclcp_pkg::result_type pending_results [$];
   row_type     rows [$];
   bit          failed;
   int          s_idle;
   int          r_idle;
   int          item_count;
   int          stall_cnt;
   logic [31:0] clk_ms;

   rc_link_command_parser DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
             c == 8'h0C || c == 8'h0D;
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit text_pre(int off, int n, string s);
      if (n < s.len()) return 0;
      for (int i = 0; i < s.len(); i++) begin
         if (folded[off+i] != s[i]) return 0;
      end
      return 1;
   endfunction

   function automatic bit text_eq(int off, int n, string s);
      return n == s.len() && text_pre(off, n, s);
   endfunction

   function automatic int pair_num(logic [7:0] c0, logic [7:0] c1);
      logic [7:0] p [0:1];
      int i;
      int v;
      bit neg;
      p[0] = c0;
      p[1] = c1;
      i = 0;
      v = 0;
      neg = 0;
      while (i < 2 && blank(p[i])) i++;
      if (i < 2 && (p[i] == rclcp_pkg::CH_PLUS || p[i] == rclcp_pkg::CH_MINUS)) begin
         neg = p[i] == rclcp_pkg::CH_MINUS;
         i++;
      end
      while (i < 2 && digit(p[i])) begin
         v = v * 10 + (p[i] - 8'h30);
         i++;
      end
      if (neg && v != 0) return 255;
      return v;
   endfunction

   function automatic bit hhmm(int off, int n, output int h, output int m);
      h = 0;
      m = 0;
      if (n != 5 || folded[off+2] != rclcp_pkg::CH_COLON) return 0;
      h = pair_num(folded[off], folded[off+1]);
      m = pair_num(folded[off+3], folded[off+4]);
      return h <= 23 && m <= 59;
   endfunction

   function automatic rclcp_pkg::result_type mk_res(rclcp_pkg::action_type a, int d, int spd,
                                                    int md, int h, int m);
      rclcp_pkg::result_type r;
      r.action = a;
      r.direction = 3'(d);
      r.speed = 8'(spd);
      r.mode = 3'(md);
      r.hour = 5'(h);
      r.minute = 6'(m);
      return r;
   endfunction

   task automatic decode_line(output bit hit, output rclcp_pkg::result_type r);
      int a;
      int b;
      int n;
      int h;
      int m;
      int rn;
      int sp;
      int s0;
      int s1;
      a = 0;
      b = line_len;
      hit = 0;
      r = '0;
      while (a < b && blank(line_buf[a])) a++;
      while (b > a && blank(line_buf[b-1])) b--;
      n = b - a;
      if (n == 0) return;
      for (int i = 0; i < n; i++) begin
         folded[i] = (line_buf[a+i] >= 8'h61 && line_buf[a+i] <= 8'h7A) ?
                     line_buf[a+i] - 8'h20 : line_buf[a+i];
      end
      hit = 1;
      if (text_eq(0, n, "MODE EVA")) begin
         r = mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_EVA, 0, 0);
      end else if (text_eq(0, n, "MODE PET")) begin
         r = mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_PET, 0, 0);
      end else if (text_eq(0, n, "MODE CLOCK")) begin
         r = mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_CLOCK, 0, 0);
      end else if (text_eq(0, n, "MODE SLEEP")) begin
         r = mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_SLEEP, 0, 0);
      end else if (text_eq(0, n, "MODE RC")) begin
         r = mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_RC, 0, 0);
      end else if (text_pre(0, n, "TIME ")) begin
         if (hhmm(5, n - 5, h, m)) r = mk_res(rclcp_pkg::ACT_SET_TIME, 0, 0, 0, h, m);
         else hit = 0;
      end else if (text_eq(0, n, "ALARM OFF")) begin
         r = mk_res(rclcp_pkg::ACT_ALARM_OFF, 0, 0, 0, 0, 0);
      end else if (text_pre(0, n, "ALARM ")) begin
         hit = 0;
         rn = n - 6;
         sp = 0;
         while (sp < rn && folded[6+sp] != rclcp_pkg::CH_SPACE) sp++;
         if (sp == 0 || sp >= rn) return;
         s0 = sp + 1;
         s1 = rn;
         while (s0 < s1 && blank(folded[6+s0])) s0++;
         while (s1 > s0 && blank(folded[6+s1-1])) s1--;
         if (!text_eq(6 + s0, s1 - s0, "ON")) return;
         if (hhmm(6, sp, h, m)) begin
            hit = 1;
            r = mk_res(rclcp_pkg::ACT_ALARM_ON, 0, 0, 0, h, m);
         end
      end else r = mk_res(rclcp_pkg::ACT_UNKNOWN, 0, 0, 0, 0, 0);
   endtask

   task automatic predict_item(bit func, logic [7:0] c, logic [31:0] now, bit rc, bit mov,
                               output bit hit, output rclcp_pkg::result_type r);
      logic [31:0] elapsed;
      hit = 0;
      r = '0;
      if (func) begin
         elapsed = now - last_cmd_ms;
         if (rc && mov && elapsed > {16'd0, wd_timeout}) begin
            hit = 1;
            r = mk_res(rclcp_pkg::ACT_STOP, 0, 0, 0, 0, 0);
         end
      end else if (c == rclcp_pkg::CH_LF || c == rclcp_pkg::CH_CR) begin
         if (line_len > 0) decode_line(hit, r);
         line_len = 0;
      end else if (line_len == 0 && (c == "F" || c == "B" || c == "L" || c == "R" ||
                   c == "G" || c == "I" || c == "H" || c == "J" || c == "S" || digit(c))) begin
         if (rc) begin
            last_cmd_ms = now;
            hit = 1;
            case (c)
               "F": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_FWD, cur_speed, 0, 0, 0);
               "B": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_BACK, cur_speed, 0, 0, 0);
               "L", "H": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_PIVOT_LEFT,
                                    cur_speed, 0, 0, 0);
               "R", "J": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_PIVOT_RIGHT,
                                    cur_speed, 0, 0, 0);
               "G": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_CURVE_LEFT,
                               cur_speed, 0, 0, 0);
               "I": r = mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_CURVE_RIGHT,
                               cur_speed, 0, 0, 0);
               "S": r = mk_res(rclcp_pkg::ACT_STOP, 0, 0, 0, 0, 0);
               default: begin
                  cur_speed = rclcp_pkg::SPEED_BASE + rclcp_pkg::SPEED_STEP * (c - 8'h30);
                  hit = 0;
               end
            endcase
         end
      end else if (line_len >= LINE_CAP) begin
         line_len = 0;
      end else begin
         line_buf[line_len] = c;
         line_len++;
      end
   endtask

   task automatic send_item(bit func, logic [7:0] c, logic [31:0] now, bit rc, bit mov,
                            bit typed, rclcp_pkg::result_type typed_res);
      bit hit;
      rclcp_pkg::result_type r;
      while ($urandom_range(0, 99) < s_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {6'd0, mov, rc, now, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(func, c, now, rc, mov, hit, r);
      if (typed) pending_results.push_back(typed_res);
      else if (hit) pending_results.push_back(r);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_line(logic [7:0] q [$], bit rc);
      foreach (q[i]) begin
         clk_ms += $urandom_range(0, 40);
         send_item(0, q[i], clk_ms, rc, 1'($urandom_range(0, 1)), 0, '0);
      end
      send_item(0, $urandom_range(0, 1) ? rclcp_pkg::CH_CR : rclcp_pkg::CH_LF, clk_ms, rc,
                0, 0, '0);
   endtask

   task automatic write_csr(logic [rclcp_pkg::CSR_INDEX_W-1:0] idx,
                            logic [rclcp_pkg::CSR_DATA_W-1:0] val);
      req_tvalid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == rclcp_pkg::REG_INITIAL_SPEED) begin
         cur_speed = val[7:0];
      end else if (idx == rclcp_pkg::REG_TIMEOUT_MS) begin
         wd_timeout = val;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void push_text(ref logic [7:0] q [$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   function automatic void push_pair(ref logic [7:0] q [$], input int lim);
      string s;
      s = $sformatf("%02d", $urandom_range(0, lim));
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: s[0] = " ";
            1: s[0] = "+";
            default: s[0] = "-";
         endcase
      end
      push_text(q, s);
   endfunction

   task automatic send_command();
      logic [7:0] q [$];
      logic [7:0] body [$];
      repeat ($urandom_range(0, 2)) q.push_back(rand_blank());
      case ($urandom_range(0, 9))
         0: push_text(body, "MODE EVA");
         1: push_text(body, "MODE PET");
         2: push_text(body, "MODE CLOCK");
         3: push_text(body, "MODE SLEEP");
         4: push_text(body, "MODE RC");
         5, 6: begin
            push_text(body, "TIME ");
            push_pair(body, 29);
            body.push_back($urandom_range(0, 15) ? rclcp_pkg::CH_COLON : 8'h2E);
            push_pair(body, 69);
            if ($urandom_range(0, 15) == 0) push_text(body, "0");
         end
         7: push_text(body, $urandom_range(0, 3) ? "ALARM OFF" : "ALARM");
         default: begin
            push_text(body, "ALARM ");
            push_pair(body, 29);
            body.push_back($urandom_range(0, 15) ? rclcp_pkg::CH_COLON : rclcp_pkg::CH_SPACE);
            push_pair(body, 69);
            push_text(body, " ");
            repeat ($urandom_range(0, 1)) body.push_back(rand_blank());
            push_text(body, $urandom_range(0, 7) ? "ON" : "OFF");
         end
      endcase
      foreach (body[i]) begin
         if (body[i] >= 8'h41 && body[i] <= 8'h5A && $urandom_range(0, 1))
            q.push_back(body[i] + 8'h20);
         else q.push_back(body[i]);
      end
      repeat ($urandom_range(0, 2)) q.push_back(rand_blank());
      send_line(q, 1'($urandom_range(0, 1)));
   endtask

   task automatic random_traffic(int count);
      logic [7:0] q [$];
      string drive_chars;
      int stop_at;
      int k;
      drive_chars = "FBLRGIHJS0123456789";
      stop_at = item_count + count;
      while (item_count < stop_at) begin
         k = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) clk_ms = $urandom;
         else clk_ms += $urandom_range(0, 600);
         if (k < 30) begin
            send_item(0, drive_chars[$urandom_range(0, drive_chars.len() - 1)], clk_ms,
                      $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), 0, '0);
         end else if (k < 50) begin
            if ($urandom_range(0, 1)) clk_ms = last_cmd_ms + wd_timeout + $urandom_range(0, 4) - 2;
            send_item(1, 8'($urandom), clk_ms, $urandom_range(0, 3) != 0,
                      $urandom_range(0, 3) != 0, 0, '0);
         end else if (k < 80) begin
            send_command();
         end else if (k < 92) begin
            q.delete();
            repeat ($urandom_range(0, 12)) q.push_back(8'($urandom_range(0, 255)));
            send_line(q, 1'($urandom_range(0, 1)));
         end else begin
            q.delete();
            repeat ($urandom_range(38, 45)) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            send_line(q, 0);
         end
      end
   endtask

   function automatic row_type mk_row(bit func, string txt, bit term, logic [31:0] now, bit rc,
                                      bit mov, bit typed, rclcp_pkg::result_type res);
      row_type r;
      r.func = func;
      r.txt = txt;
      r.term = term;
      r.now = now;
      r.rc = rc;
      r.mov = mov;
      r.typed = typed;
      r.res = res;
      return r;
   endfunction

   task automatic run_directed();
      rclcp_pkg::result_type none;
      rclcp_pkg::result_type stop_res;
      rclcp_pkg::result_type unk_res;
      none = '0;
      stop_res = mk_res(rclcp_pkg::ACT_STOP, 0, 0, 0, 0, 0);
      unk_res = mk_res(rclcp_pkg::ACT_UNKNOWN, 0, 0, 0, 0, 0);
      rows.push_back(mk_row(0, "F", 0, 10, 1, 0, 1,
                            mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_FWD, 200, 0, 0, 0)));
      rows.push_back(mk_row(0, "9", 0, 20, 1, 0, 0, none));
      rows.push_back(mk_row(0, "I", 0, 30, 1, 0, 1,
                            mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_CURVE_RIGHT, 255,
                                   0, 0, 0)));
      rows.push_back(mk_row(0, "S", 0, 40, 1, 1, 1, stop_res));
      rows.push_back(mk_row(0, "F", 0, 50, 0, 0, 0, none));
      rows.push_back(mk_row(0, "0", 0, 60, 1, 0, 0, none));
      rows.push_back(mk_row(0, "L", 0, 100, 1, 1, 1,
                            mk_res(rclcp_pkg::ACT_DRIVE, rclcp_pkg::DIR_PIVOT_LEFT, 120,
                                   0, 0, 0)));
      rows.push_back(mk_row(1, "", 0, 1600, 1, 1, 0, none));
      rows.push_back(mk_row(1, "", 0, 1601, 1, 1, 1, stop_res));
      rows.push_back(mk_row(1, "", 0, 32'hFFFF_FFFF, 0, 1, 0, none));
      rows.push_back(mk_row(1, "", 0, 32'hFFFF_FFFF, 1, 0, 0, none));
      rows.push_back(mk_row(1, "", 0, 32'h0000_0063, 1, 1, 1, stop_res));
      rows.push_back(mk_row(0, "  mode clock \t", 1, 200, 1, 0, 1,
                            mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_CLOCK,
                                   0, 0)));
      rows.push_back(mk_row(0, "MODE RC", 1, 210, 0, 0, 1,
                            mk_res(rclcp_pkg::ACT_SET_MODE, 0, 0, rclcp_pkg::CMD_MODE_RC,
                                   0, 0)));
      rows.push_back(mk_row(0, "time 23:59", 1, 220, 0, 0, 1,
                            mk_res(rclcp_pkg::ACT_SET_TIME, 0, 0, 0, 23, 59)));
      rows.push_back(mk_row(0, "TIME 24:00", 1, 230, 0, 0, 0, none));
      rows.push_back(mk_row(0, "alarm 07:05 on", 1, 240, 0, 0, 1,
                            mk_res(rclcp_pkg::ACT_ALARM_ON, 0, 0, 0, 7, 5)));
      rows.push_back(mk_row(0, "ALARM OFF", 1, 250, 0, 0, 1,
                            mk_res(rclcp_pkg::ACT_ALARM_OFF, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(0, "ALARM", 1, 260, 0, 0, 1, unk_res));
      rows.push_back(mk_row(0, "ALARM -1:05 ON", 1, 270, 0, 0, 0, none));
      rows.push_back(mk_row(0, "   ", 1, 280, 0, 0, 0, none));
      rows.push_back(mk_row(0, "", 1, 290, 0, 0, 0, none));
      rows.push_back(mk_row(0, "\377", 1, 300, 0, 0, 1, unk_res));
      rows.push_back(mk_row(0, "x123456789012345678901234567890123456789", 1, 310, 0, 0, 1,
                            unk_res));
      rows.push_back(mk_row(0, "x123456789012345678901234567890123456789Z", 1, 320, 0, 0, 0,
                            none));
      foreach (rows[i]) begin
         if (rows[i].func) begin
            send_item(1, 8'h00, rows[i].now, rows[i].rc, rows[i].mov, rows[i].typed, rows[i].res);
         end else begin
            for (int j = 0; j < rows[i].txt.len(); j++) begin
               send_item(0, rows[i].txt[j], rows[i].now, rows[i].rc, rows[i].mov,
                         rows[i].typed && !rows[i].term && j == rows[i].txt.len() - 1,
                         rows[i].res);
            end
            if (rows[i].term) begin
               send_item(0, rclcp_pkg::CH_CR, rows[i].now, rows[i].rc, rows[i].mov,
                         rows[i].typed, rows[i].res);
            end
         end
      end
   endtask

   task automatic check_field(string name, int e, int g);
      if (e != g) begin
         failed = 1;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, g);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      rclcp_pkg::result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            failed = 1;
            $display("%0t unexpected result expected none actual action %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            exp_r = pending_results.pop_front();
            check_field("action", exp_r.action, rsp_tuser);
            check_field("direction", exp_r.direction, rsp_tdata[2:0]);
            check_field("speed", exp_r.speed, rsp_tdata[10:3]);
            check_field("mode", exp_r.mode, rsp_tdata[13:11]);
            check_field("hour", exp_r.hour, rsp_tdata[18:14]);
            check_field("minute", exp_r.minute, rsp_tdata[24:19]);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready = $urandom_range(0, 99) >= r_idle;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cnt = 0;
      end else begin
         stall_cnt++;
         if (stall_cnt == STALL_LIMIT) begin
            $display("rc_link_command_parser verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      failed = 0;
      item_count = 0;
      stall_cnt = 0;
      clk_ms = 0;
      s_idle = 29;
      r_idle = 56;
      line_len = 0;
      cur_speed = rclcp_pkg::INIT_SPEED_RESET;
      wd_timeout = rclcp_pkg::TIMEOUT_RESET;
      last_cmd_ms = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      write_csr(rclcp_pkg::REG_INITIAL_SPEED, 16'h00FF);
      write_csr(rclcp_pkg::REG_TIMEOUT_MS, 16'd0);
      random_traffic(450);
      s_idle = 56;
      r_idle = 29;
      write_csr(rclcp_pkg::REG_INITIAL_SPEED, 16'h0000);
      write_csr(rclcp_pkg::REG_TIMEOUT_MS, 16'hFFFF);
      random_traffic(450);
      s_idle = 0;
      r_idle = 0;
      write_csr(rclcp_pkg::REG_INITIAL_SPEED, 16'($urandom_range(0, 255)));
      write_csr(rclcp_pkg::REG_TIMEOUT_MS, rclcp_pkg::TIMEOUT_RESET);
      random_traffic(450);
      req_tvalid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("rc_link_command_parser verification clean");
      end else begin
         $display("rc_link_command_parser verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rclcp_pkg.sv
hw/rtl/rclcp_ctrl.sv
hw/rtl/rclcp_datapath.sv
hw/rtl/rc_link_command_parser.sv
hw/rtl/rclcp_checker.sv
verif/tb_top.sv
